>>> design/sct_pkg.sv
// Shared types, character codes and lexer step function for the script tokenizer.
package sct_pkg;

    localparam int LINE_BITS  = 32;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int SPACE_BITS = $clog2(QDEPTH + 1);

    localparam logic [2:0] MODE_BETWEEN = 3'd0;
    localparam logic [2:0] MODE_TOKEN   = 3'd1;
    localparam logic [2:0] MODE_SLASH   = 3'd2;
    localparam logic [2:0] MODE_COMMENT = 3'd3;
    localparam logic [2:0] MODE_QUOTED  = 3'd4;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic        has_char;
        logic [7:0]  token_byte;
        logic        token_end;
        logic        is_quoted;
        logic [31:0] line_number;
        logic        unterminated_quote;
    } result_t;

    typedef struct packed {
        logic [1:0]       cnt;
        result_t [2:0]    entry;
    } push_t;

    typedef struct packed {
        logic       has_char;
        logic [7:0] token_byte;
        logic       token_end;
        logic       is_quoted;
        logic       unterminated_quote;
    } lex_res_t;

    typedef struct packed {
        logic [2:0]     mode;
        logic           tok_open;
        logic [1:0]     cnt;
        lex_res_t [1:0] res;
    } lex_out_t;

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic lex_res_t mk_res(logic has, logic [7:0] byte_val, logic end_flag,
                                        logic quoted, logic err);
        lex_res_t r;
        r.has_char           = has;
        r.token_byte         = byte_val;
        r.token_end          = end_flag;
        r.is_quoted          = quoted;
        r.unterminated_quote = err;
        return r;
    endfunction

    function automatic lex_out_t lex_add(lex_out_t o, lex_res_t e);
        lex_out_t r;
        r = o;
        r.res[o.cnt[0]] = e;
        r.cnt = o.cnt + 2'd1;
        return r;
    endfunction

    function automatic lex_out_t token_lex(lex_out_t o, logic [7:0] c, logic eof);
        lex_out_t r;
        r = o;
        if (eof || is_ws(c))
        begin
            r = lex_add(r, mk_res(1'b0, 8'd0, 1'b1, 1'b0, 1'b0));
            r.tok_open = 1'b0;
            r.mode = MODE_BETWEEN;
        end
        else if (c == CH_SEMI || c == CH_HASH)
        begin
            r.mode = MODE_COMMENT;
        end
        else if (c == CH_SLASH)
        begin
            r.mode = MODE_SLASH;
        end
        else
        begin
            r = lex_add(r, mk_res(1'b1, c, 1'b0, 1'b0, 1'b0));
        end
        return r;
    endfunction

    // One character through the lexer, giving at most two results.
    function automatic lex_out_t lex_step(logic [2:0] mode, logic tok, logic [7:0] c,
                                          logic eof);
        lex_out_t o;
        o.mode = mode;
        o.tok_open = tok;
        o.cnt = 2'd0;
        o.res = '0;
        unique case (mode)
            MODE_QUOTED:
            begin
                if (eof)
                begin
                    o = lex_add(o, mk_res(1'b0, 8'd0, 1'b1, 1'b1, 1'b1));
                end
                else if (c == CH_QUOTE)
                begin
                    o = lex_add(o, mk_res(1'b0, 8'd0, 1'b1, 1'b1, 1'b0));
                    o.mode = MODE_BETWEEN;
                end
                else
                begin
                    o = lex_add(o, mk_res(1'b1, c, 1'b0, 1'b1, 1'b0));
                end
            end
            MODE_COMMENT:
            begin
                if (eof || c == CH_NEWLINE)
                begin
                    if (tok)
                    begin
                        o = lex_add(o, mk_res(1'b0, 8'd0, 1'b1, 1'b0, 1'b0));
                    end
                    o.tok_open = 1'b0;
                    o.mode = MODE_BETWEEN;
                end
            end
            MODE_SLASH:
            begin
                if (!eof && c == CH_SLASH)
                begin
                    o.mode = MODE_COMMENT;
                end
                else
                begin
                    o = lex_add(o, mk_res(1'b1, CH_SLASH, 1'b0, 1'b0, 1'b0));
                    o.tok_open = 1'b1;
                    o.mode = MODE_TOKEN;
                    o = token_lex(o, c, eof);
                end
            end
            MODE_TOKEN:
            begin
                o = token_lex(o, c, eof);
            end
            default:
            begin
                if (!eof && !is_ws(c))
                begin
                    if (c == CH_SLASH)
                    begin
                        o.tok_open = 1'b0;
                        o.mode = MODE_SLASH;
                    end
                    else if (c == CH_SEMI || c == CH_HASH)
                    begin
                        o.tok_open = 1'b0;
                        o.mode = MODE_COMMENT;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        o.mode = MODE_QUOTED;
                    end
                    else
                    begin
                        o = lex_add(o, mk_res(1'b1, c, 1'b0, 1'b0, 1'b0));
                        o.tok_open = 1'b1;
                        o.mode = MODE_TOKEN;
                    end
                end
            end
        endcase
        return o;
    endfunction

endpackage

>>> design/script_char_tokenizer_top.sv
// Top level of the script tokenizer: step logic feeding the result queue.
//
// Each transaction on the item channel carries one script byte or an end-of-input
// mark, and the block answers with zero to three result transactions carrying token
// characters, token-end markers, the current line number and an unterminated-quote
// flag. An accepted item is registered, processed once the queue has room for all of
// its results, and those results are written together into a four-entry result queue,
// which returns one result per cycle while the output is ready. Items are taken one per
// cycle as long as the queue has room for all of an item's results; an item that yields
// two or three results holds the output side until all of them are taken. The first
// result of an item passes the input register and then the result queue before it is
// valid on the output. End of input returns all lexer state to its reset values.
module script_char_tokenizer_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  sct_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output sct_pkg::result_t result
);
    import sct_pkg::*;

    push_t                 push;
    logic [SPACE_BITS-1:0] space;

    sct_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .space      (space),
        .push       (push)
    );

    sct_res_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .space        (space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> design/sct_step.sv
// Input register, lexer state and the per-byte step logic of the script tokenizer.
module sct_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  sct_pkg::item_t                item,
    input  logic [sct_pkg::SPACE_BITS-1:0] space,
    output sct_pkg::push_t                push
);
    import sct_pkg::*;

    logic                 in_valid_reg;
    item_t                in_item_reg;
    logic [2:0]           mode_reg, mode_next;
    logic                 tok_reg, tok_next;
    logic                 bp_reg, bp_next;
    logic                 raw_reg, raw_next;
    logic [LINE_BITS-1:0] line_reg, line_next;

    logic [LINE_BITS-1:0] line_inc;
    logic [LINE_BITS-1:0] line_out;
    logic                 eof;
    logic [7:0]           c;
    logic                 do_a, do_b;
    lex_out_t             lex_a, lex_b;
    logic [2:0]           mid_mode;
    logic                 mid_tok;
    logic [1:0]           cnt_a, cnt_b, n_total;
    lex_res_t [2:0]       ent;
    logic                 fire;

    always_comb
    begin
        eof = in_item_reg.end_of_input;
        c = in_item_reg.char_in;
        line_inc = (c == CH_NEWLINE) ? line_reg + LINE_BITS'(1) : line_reg;
        line_out = eof ? line_reg : line_inc;

        do_a = eof ? bp_reg : (!raw_reg && bp_reg && c != CH_NEWLINE);
        do_b = eof ? 1'b1 : (raw_reg || (c != CH_BACKSLASH && !(bp_reg && c == CH_NEWLINE)));

        lex_a = lex_step(mode_reg, tok_reg, CH_BACKSLASH, 1'b0);
        mid_mode = do_a ? lex_a.mode : mode_reg;
        mid_tok = do_a ? lex_a.tok_open : tok_reg;
        lex_b = lex_step(mid_mode, mid_tok, c, eof);

        cnt_a = do_a ? lex_a.cnt : 2'd0;
        cnt_b = do_b ? lex_b.cnt : 2'd0;
        n_total = cnt_a + cnt_b;

        ent = '0;
        unique case (cnt_a)
            2'd0:
            begin
                ent[0] = lex_b.res[0];
                ent[1] = lex_b.res[1];
            end
            2'd1:
            begin
                ent[0] = lex_a.res[0];
                ent[1] = lex_b.res[0];
                ent[2] = lex_b.res[1];
            end
            default:
            begin
                ent[0] = lex_a.res[0];
                ent[1] = lex_a.res[1];
                ent[2] = lex_b.res[0];
            end
        endcase

        fire = in_valid_reg && (SPACE_BITS'(n_total) <= space);
        item_ready = !in_valid_reg || fire;

        push.cnt = fire ? n_total : 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            push.entry[i].has_char           = ent[i].has_char;
            push.entry[i].token_byte         = ent[i].token_byte;
            push.entry[i].token_end          = ent[i].token_end;
            push.entry[i].is_quoted          = ent[i].is_quoted;
            push.entry[i].line_number        = 32'(line_out);
            push.entry[i].unterminated_quote = ent[i].unterminated_quote;
        end

        mode_next = mode_reg;
        tok_next = tok_reg;
        bp_next = bp_reg;
        raw_next = raw_reg;
        line_next = line_reg;
        if (fire)
        begin
            if (eof)
            begin
                mode_next = MODE_BETWEEN;
                tok_next = 1'b0;
                bp_next = 1'b0;
                raw_next = 1'b0;
                line_next = LINE_BITS'(1);
            end
            else
            begin
                mode_next = do_b ? lex_b.mode : mid_mode;
                tok_next = do_b ? lex_b.tok_open : mid_tok;
                bp_next = !raw_reg && c == CH_BACKSLASH;
                raw_next = !raw_reg && bp_reg && c == CH_NEWLINE;
                line_next = line_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg <= MODE_BETWEEN;
            tok_reg <= 1'b0;
            bp_reg <= 1'b0;
            raw_reg <= 1'b0;
            line_reg <= LINE_BITS'(1);
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            mode_reg <= mode_next;
            tok_reg <= tok_next;
            bp_reg <= bp_next;
            raw_reg <= raw_next;
            line_reg <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_item_reg <= item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(raw_reg && bp_reg))
        else $error("Continuation flags set together.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && eof) |=> (mode_reg == MODE_BETWEEN && !tok_reg && line_reg == LINE_BITS'(1)))
        else $error("State not restored after end of input.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("Held transaction lost before processing.");

endmodule

>>> design/sct_res_queue.sv
// Small result queue that takes up to three results per cycle and hands out one.
module sct_res_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sct_pkg::push_t                 push,
    output logic [sct_pkg::SPACE_BITS-1:0] space,
    output logic                           result_valid,
    input  logic                           result_ready,
    output sct_pkg::result_t               result
);
    import sct_pkg::*;

    result_t               mem [QDEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [SPACE_BITS-1:0] count_reg, count_next;
    logic                  pop;

    always_comb
    begin
        result_valid = count_reg != '0;
        result = mem[rd_ptr_reg];
        pop = result_valid && result_ready;
        space = SPACE_BITS'(QDEPTH) - count_reg + SPACE_BITS'(pop);
        count_next = count_reg + SPACE_BITS'(push.cnt) - SPACE_BITS'(pop);
        wr_ptr_next = wr_ptr_reg + QPTR_BITS'(push.cnt);
        rd_ptr_next = rd_ptr_reg + QPTR_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (i < int'(push.cnt))
            begin
                mem[wr_ptr_reg + QPTR_BITS'(i)] <= push.entry[i];
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= SPACE_BITS'(QDEPTH))
        else $error("Result queue over capacity.");

    assert property (@(posedge clk) disable iff (!rst_n) SPACE_BITS'(push.cnt) <= space)
        else $error("Results pushed beyond free space.");

    assert property (@(posedge clk) disable iff (!rst_n) (push.cnt != 2'd0) |=> result_valid)
        else $error("Pushed results not offered.");

endmodule

>>> tb/token_stream_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the tokenizer's result stream and compares it with the block's output.
module token_stream_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_ready,
    input  sct_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_ready,
    input  sct_pkg::result_t result,
    output int               fail_count,
    output int               outstanding
);

    import sct_pkg::*;

    logic [2:0]  scan_mode;
    logic        held_backslash;
    logic        take_literal;
    logic        token_has_text;
    logic [31:0] lines_seen;
    result_t     expected_results[$];
    result_t     want;
    int          mismatches = 0;
    int          waiting = 0;

    assign fail_count  = mismatches;
    assign outstanding = waiting;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    task automatic push_result(input logic has, input logic [7:0] ch, input logic fin,
                               input logic quoted, input logic err);
        result_t r;
        r.has_char           = has;
        r.token_byte         = ch;
        r.token_end          = fin;
        r.is_quoted          = quoted;
        r.line_number        = lines_seen;
        r.unterminated_quote = err;
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic clear_state();
        scan_mode      = MODE_BETWEEN;
        held_backslash = 1'b0;
        take_literal   = 1'b0;
        token_has_text = 1'b0;
        lines_seen     = 32'd1;
    endtask

    task automatic token_char(input logic [7:0] c, input logic eof);
        if (eof || is_blank(c))
        begin
            push_result(1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
            token_has_text = 1'b0;
            scan_mode = MODE_BETWEEN;
        end
        else if (c == CH_SEMI || c == CH_HASH)
        begin
            scan_mode = MODE_COMMENT;
        end
        else if (c == CH_SLASH)
        begin
            scan_mode = MODE_SLASH;
        end
        else
        begin
            push_result(1'b1, c, 1'b0, 1'b0, 1'b0);
        end
    endtask

    task automatic scan_char(input logic [7:0] c, input logic eof);
        case (scan_mode)
            MODE_QUOTED:
            begin
                if (eof)
                begin
                    push_result(1'b0, 8'd0, 1'b1, 1'b1, 1'b1);
                end
                else if (c == CH_QUOTE)
                begin
                    push_result(1'b0, 8'd0, 1'b1, 1'b1, 1'b0);
                    scan_mode = MODE_BETWEEN;
                end
                else
                begin
                    push_result(1'b1, c, 1'b0, 1'b1, 1'b0);
                end
            end
            MODE_COMMENT:
            begin
                if (eof || c == CH_NEWLINE)
                begin
                    if (token_has_text)
                    begin
                        push_result(1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
                    end
                    token_has_text = 1'b0;
                    scan_mode = MODE_BETWEEN;
                end
            end
            MODE_SLASH:
            begin
                if (!eof && c == CH_SLASH)
                begin
                    scan_mode = MODE_COMMENT;
                end
                else
                begin
                    push_result(1'b1, CH_SLASH, 1'b0, 1'b0, 1'b0);
                    token_has_text = 1'b1;
                    scan_mode = MODE_TOKEN;
                    token_char(c, eof);
                end
            end
            MODE_TOKEN:
            begin
                token_char(c, eof);
            end
            default:
            begin
                if (!eof && !is_blank(c))
                begin
                    if (c == CH_SLASH)
                    begin
                        token_has_text = 1'b0;
                        scan_mode = MODE_SLASH;
                    end
                    else if (c == CH_SEMI || c == CH_HASH)
                    begin
                        token_has_text = 1'b0;
                        scan_mode = MODE_COMMENT;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        scan_mode = MODE_QUOTED;
                    end
                    else
                    begin
                        push_result(1'b1, c, 1'b0, 1'b0, 1'b0);
                        token_has_text = 1'b1;
                        scan_mode = MODE_TOKEN;
                    end
                end
            end
        endcase
    endtask

    task automatic predict_item(input item_t it);
        logic [7:0] c;
        c = it.char_in;
        if (it.end_of_input)
        begin
            if (held_backslash)
            begin
                held_backslash = 1'b0;
                scan_char(CH_BACKSLASH, 1'b0);
            end
            scan_char(8'd0, 1'b1);
            clear_state();
        end
        else
        begin
            if (c == CH_NEWLINE)
            begin
                lines_seen = lines_seen + 32'd1;
            end
            if (take_literal)
            begin
                take_literal = 1'b0;
                scan_char(c, 1'b0);
            end
            else if (held_backslash)
            begin
                held_backslash = 1'b0;
                if (c == CH_NEWLINE)
                begin
                    take_literal = 1'b1;
                end
                else
                begin
                    scan_char(CH_BACKSLASH, 1'b0);
                    if (c == CH_BACKSLASH)
                    begin
                        held_backslash = 1'b1;
                    end
                    else
                    begin
                        scan_char(c, 1'b0);
                    end
                end
            end
            else if (c == CH_BACKSLASH)
            begin
                held_backslash = 1'b1;
            end
            else
            begin
                scan_char(c, 1'b0);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            expected_results.delete();
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, actual %h",
                             $time, result);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("has_char", 32'(want.has_char), 32'(result.has_char));
                    check_field("token_byte", 32'(want.token_byte), 32'(result.token_byte));
                    check_field("token_end", 32'(want.token_end), 32'(result.token_end));
                    check_field("is_quoted", 32'(want.is_quoted), 32'(result.is_quoted));
                    check_field("line_number", want.line_number, result.line_number);
                    check_field("unterminated_quote", 32'(want.unterminated_quote),
                                32'(result.unterminated_quote));
                end
            end
            if (item_valid && item_ready)
            begin
                predict_item(item);
            end
        end
        waiting = expected_results.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Top of the tokenizer testbench: clock, reset, stimulus, output stalls and the verdict.
module tb;

    import sct_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;
    int      fail_count;
    int      outstanding;

    item_t   script[$];
    bit      feed_gaps = 1'b1;
    bit      drain_stalls = 1'b1;

    script_char_tokenizer_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    token_stream_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic add_item(input logic [7:0] c, input logic eof);
        item_t it;
        it.char_in = c;
        it.end_of_input = eof;
        script.insert(script.size(), it);
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input item_t it);
        int gap;
        if ($urandom_range(0, 39) == 0)
        begin
            feed_gaps = !feed_gaps;
        end
        gap = feed_gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
    endtask

    initial
    begin
        int         r;
        int         n;
        logic [7:0] c;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;

        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(CH_SPACE, 1'b0);
        add_item(CH_QUOTE, 1'b0);
        add_item(CH_TAB, 1'b0);
        add_item(CH_QUOTE, 1'b0);
        add_item(CH_QUOTE, 1'b0);
        add_item(CH_QUOTE, 1'b0);
        add_item(CH_SLASH, 1'b0);
        add_item(CH_SEMI, 1'b0);
        add_item(CH_NEWLINE, 1'b0);
        add_item(CH_SLASH, 1'b0);
        add_item(CH_SLASH, 1'b0);
        add_item(CH_NEWLINE, 1'b0);
        add_item("q", 1'b0);
        add_item(CH_QUOTE, 1'b0);
        add_item(CH_HASH, 1'b0);
        add_item(8'h00, 1'b1);
        add_item(CH_SLASH, 1'b0);
        add_item(CH_BACKSLASH, 1'b0);
        add_item(8'hFF, 1'b1);
        add_item("k", 1'b0);
        add_item(CH_BACKSLASH, 1'b0);
        add_item(CH_NEWLINE, 1'b0);
        add_item(CH_NEWLINE, 1'b0);
        add_item(CH_BACKSLASH, 1'b0);
        add_item(8'h00, 1'b1);
        add_item(CH_QUOTE, 1'b0);
        add_item(8'h55, 1'b1);

        while (script.size() < 420)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                c = 8'($urandom_range(33, 126));
                add_item(c, 1'b0);
            end
            else if (r < 44)
            begin
                c = 8'($urandom_range(8, 13));
                add_item((c == 8'd8) ? CH_SPACE : c, 1'b0);
            end
            else if (r < 52)
            begin
                add_item(CH_NEWLINE, 1'b0);
            end
            else if (r < 60)
            begin
                add_item(CH_QUOTE, 1'b0);
            end
            else if (r < 65)
            begin
                add_item($urandom_range(0, 1) ? CH_SEMI : CH_HASH, 1'b0);
            end
            else if (r < 72)
            begin
                add_item(CH_SLASH, 1'b0);
            end
            else if (r < 79)
            begin
                add_item(CH_BACKSLASH, 1'b0);
                if ($urandom_range(0, 1))
                begin
                    add_item(CH_NEWLINE, 1'b0);
                end
            end
            else if (r < 96)
            begin
                c = 8'($urandom_range(0, 255));
                add_item(c, 1'b0);
            end
            else
            begin
                c = 8'($urandom_range(0, 255));
                add_item(c, 1'b1);
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (script[i])
        begin
            send_item(script[i]);
        end
        item_valid <= 1'b0;

        n = 0;
        while (outstanding != 0 && n < 5000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (10) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                drain_stalls = !drain_stalls;
            end
            gap = drain_stalls ? $urandom_range(0, 13) : 0;
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
